@@ hdl/pact_pkg.sv @@
// Shared types, field widths and codes for the arbiter channel translator.
// No dependencies; imported by every module of the block.
package pact_pkg;

    // Field widths fixed by the bus format
    localparam int CMD_W     = 2;
    localparam int CHAN_W    = 9;
    localparam int MAP_W     = 32;
    localparam int ENV_W     = 3;
    localparam int SID_W     = 4;
    localparam int ADDR_W    = 16;
    localparam int LEN_W     = 4;
    localparam int DATA_W    = 64;
    localparam int STATUS_W  = 2;
    localparam int OFFSET_W  = 25;
    localparam int CWORD_W   = 28;
    localparam int WORD_W    = 32;
    localparam int PID_W     = 12;
    localparam int SLOT_W    = CHAN_W + 1;
    localparam int MAX_LEN   = 8;

    // Default sizes
    localparam int DEF_PERIPH_IDS  = 4096;
    localparam int DEF_CHANNELS    = 512;
    localparam int DEF_QUEUE_DEPTH = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNSUP = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_LEN   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_PERIPH = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DENIED    = 2'd3;

    // Register block select
    localparam logic BLK_OBSERVER = 1'b0;
    localparam logic BLK_CHANNEL  = 1'b1;

    // Work classes decided by the front end
    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_READ,
        KIND_WRITE,
        KIND_BAD
    } kind_t;

    // One classified transaction waiting for the back end
    typedef struct packed {
        kind_t               kind;
        logic [PID_W-1:0]    pid;
        logic                pid_ok;
        logic [CHAN_W-1:0]   chan;
        logic [ENV_W-1:0]    owner;
        logic [CWORD_W-1:0]  cword;
        logic [WORD_W-1:0]   wlo;
        logic [WORD_W-1:0]   whi;
    } entry_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

@@ hdl/pact_front.sv @@
// Front end: accepts input transactions, classifies them and pushes work entries.
// Depends on pact_pkg; feeds pact_queue.
module pact_front
    import pact_pkg::*;
#(
    parameter int PERIPH_IDS = DEF_PERIPH_IDS,
    parameter int CHANNELS   = DEF_CHANNELS
)
(
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [CHAN_W-1:0]   channel_index,
    input  logic [MAP_W-1:0]    map_word,
    input  logic [ENV_W-1:0]    owner_word,
    input  logic [SID_W-1:0]    slave_id,
    input  logic [ADDR_W-1:0]   reg_address,
    input  logic [LEN_W-1:0]    byte_count,
    input  logic [DATA_W-1:0]   write_data,
    input  logic                busy,
    input  q_status_t           q_status,
    output logic                push,
    output entry_t              push_entry
);

    localparam int PID_CMP_W  = PID_W + 1;
    localparam int CHAN_CMP_W = CHAN_W + 1;

    logic [PID_W-1:0]  pid;
    logic              load_nop;
    logic              len_bad;
    logic [DATA_W-1:0] data_masked;

    // Stall while the slot table clears or the queue is full
    assign in_stall = busy || q_status.full;

    // Peripheral id: from the map word for loads, slave and address high byte otherwise
    assign pid = (cmd == CMD_LOAD) ? map_word[19:8] : {slave_id, reg_address[15:8]};

    // Loads with an empty map word or an out-of-range channel are dropped here
    assign load_nop = (map_word == '0) ||
                      ({1'b0, channel_index} >= CHAN_CMP_W'(CHANNELS));

    assign len_bad = (byte_count == '0) || (byte_count > LEN_W'(MAX_LEN)) ||
                     (cmd == CMD_UNSUP);

    // Zero the bytes past the transfer length
    always_comb
    begin
        for (int i = 0; i < MAX_LEN; i++)
        begin
            data_masked[i*8 +: 8] = (LEN_W'(i) < byte_count) ? write_data[i*8 +: 8] : 8'h00;
        end
    end

    // Build the work entry
    always_comb
    begin
        push_entry        = '0;
        push_entry.pid    = pid;
        push_entry.pid_ok = ({1'b0, pid} < PID_CMP_W'(PERIPH_IDS));
        push_entry.chan   = channel_index;
        push_entry.owner  = owner_word;
        push_entry.cword  = {(cmd == CMD_READ), 15'd0, reg_address[7:0], 1'b0,
                             3'(byte_count - 4'd1)};
        push_entry.wlo    = data_masked[WORD_W-1:0];
        push_entry.whi    = data_masked[DATA_W-1:WORD_W];
        if (cmd == CMD_LOAD)
        begin
            push_entry.kind = KIND_LOAD;
        end
        else if (len_bad)
        begin
            push_entry.kind = KIND_BAD;
        end
        else if (cmd == CMD_READ)
        begin
            push_entry.kind = KIND_READ;
        end
        else
        begin
            push_entry.kind = KIND_WRITE;
        end
    end

    assign push = in_valid && !in_stall && !((cmd == CMD_LOAD) && load_nop);

endmodule

@@ hdl/pact_queue.sv @@
// Short work queue between the front and back ends.
// Depends on pact_pkg for the entry and status types.
module pact_queue
    import pact_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  entry_t    push_entry,
    input  logic      pop,
    output entry_t    head,
    output q_status_t q_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;

    assign q_status.full  = (count_reg == CNT_W'(DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign head           = store_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ hdl/pact_back.sv @@
// Back end: sequencer over the slot and writer tables, builds result transactions.
// Depends on pact_pkg; pulls work entries from pact_queue.
module pact_back
    import pact_pkg::*;
#(
    parameter int PERIPH_IDS = DEF_PERIPH_IDS,
    parameter int CHANNELS   = DEF_CHANNELS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [ENV_W-1:0]     own_env,
    input  entry_t               head,
    input  q_status_t            q_status,
    output logic                 pop,
    output logic                 busy,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [STATUS_W-1:0]  status,
    output logic [CHAN_W-1:0]    channel_out,
    output logic                 reg_block,
    output logic [OFFSET_W-1:0]  reg_offset,
    output logic [CWORD_W-1:0]   command_word,
    output logic [WORD_W-1:0]    write_word_lo,
    output logic [WORD_W-1:0]    write_word_hi
);

    localparam int PID_IDX_W  = (PERIPH_IDS > 1) ? $clog2(PERIPH_IDS) : 1;
    localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CHAN_CMP_W = CHAN_W + 1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_PERM
    } state_t;

    state_t                 state_reg, state_next;
    logic [PID_IDX_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic                   out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [CHAN_W-1:0]      chan_out_reg, chan_out_next;
    logic                   block_reg, block_next;
    logic [OFFSET_W-1:0]    offset_reg, offset_next;
    logic [CWORD_W-1:0]     cword_reg, cword_next;
    logic [WORD_W-1:0]      wlo_reg, wlo_next;
    logic [WORD_W-1:0]      whi_reg, whi_next;

    // Tables and their registered read data
    logic [SLOT_W-1:0]      slot_mem [PERIPH_IDS];
    logic [ENV_W-1:0]       writer_mem [CHANNELS];
    entry_t                 work_reg;
    logic [SLOT_W-1:0]      slot_q_reg;
    logic [ENV_W-1:0]       writer_q_reg;

    logic                   slot_we;
    logic [PID_IDX_W-1:0]   slot_waddr;
    logic [SLOT_W-1:0]      slot_wdata;
    logic                   writer_we;
    logic                   writer_re;
    logic                   slot_hit;
    logic [CHAN_W-1:0]      slot_chan;
    logic                   chan_ok;
    logic                   out_free;

    assign busy          = (state_reg == S_CLEAR);
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign channel_out   = chan_out_reg;
    assign reg_block     = block_reg;
    assign reg_offset    = offset_reg;
    assign command_word  = cword_reg;
    assign write_word_lo = wlo_reg;
    assign write_word_hi = whi_reg;

    assign slot_hit  = work_reg.pid_ok && slot_q_reg[SLOT_W-1];
    assign slot_chan = slot_q_reg[CHAN_W-1:0];
    assign chan_ok   = ({1'b0, slot_chan} < CHAN_CMP_W'(CHANNELS));
    assign out_free  = !out_valid_reg || !out_stall;

    // Take the next entry; requests wait for room in the output register
    assign pop = (state_reg == S_IDLE) && !q_status.empty &&
                 ((head.kind == KIND_LOAD) || out_free);

    // Table write controls: clearing sweep or map load
    always_comb
    begin
        slot_we    = 1'b0;
        slot_waddr = clr_cnt_reg;
        slot_wdata = '0;
        writer_we  = 1'b0;
        if (state_reg == S_CLEAR)
        begin
            slot_we = 1'b1;
        end
        else if ((state_reg == S_EVAL) && (work_reg.kind == KIND_LOAD))
        begin
            writer_we  = 1'b1;
            slot_waddr = work_reg.pid[PID_IDX_W-1:0];
            slot_wdata = {1'b1, work_reg.chan};
            slot_we    = work_reg.pid_ok &&
                         (!slot_q_reg[SLOT_W-1] || (work_reg.owner == own_env));
        end
    end

    assign writer_re = (state_reg == S_EVAL) && (work_reg.kind == KIND_WRITE) &&
                       slot_hit && chan_ok;

    // Slot table
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        if (pop)
        begin
            slot_q_reg <= slot_mem[head.pid[PID_IDX_W-1:0]];
        end
    end

    // Channel writer table
    always_ff @(posedge clk)
    begin
        if (writer_we)
        begin
            writer_mem[work_reg.chan[CH_IDX_W-1:0]] <= work_reg.owner;
        end
        if (writer_re)
        begin
            writer_q_reg <= writer_mem[slot_chan[CH_IDX_W-1:0]];
        end
    end

    // Working entry
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            work_reg <= head;
        end
    end

    // Sequencer and result build
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        chan_out_next  = chan_out_reg;
        block_next     = block_reg;
        offset_next    = offset_reg;
        cword_next     = cword_reg;
        wlo_next       = wlo_reg;
        whi_next       = whi_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == PID_IDX_W'(PERIPH_IDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (pop)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_IDLE;
                if (work_reg.kind != KIND_LOAD)
                begin
                    status_next   = ST_OK;
                    chan_out_next = '0;
                    block_next    = BLK_OBSERVER;
                    offset_next   = '0;
                    cword_next    = '0;
                    wlo_next      = '0;
                    whi_next      = '0;
                    if (work_reg.kind == KIND_BAD)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = ST_BAD_LEN;
                    end
                    else if (!slot_hit)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = ST_NO_PERIPH;
                    end
                    else if (work_reg.kind == KIND_READ)
                    begin
                        out_valid_next = 1'b1;
                        chan_out_next  = slot_chan;
                        offset_next    = {6'd0, own_env, slot_chan, 7'd0};
                        cword_next     = work_reg.cword;
                    end
                    else if (!chan_ok)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = ST_DENIED;
                        chan_out_next  = slot_chan;
                    end
                    else
                    begin
                        state_next = S_PERM;
                    end
                end
            end
            S_PERM:
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b1;
                chan_out_next  = slot_chan;
                if (writer_q_reg == own_env)
                begin
                    status_next = ST_OK;
                    block_next  = BLK_CHANNEL;
                    offset_next = {slot_chan, 16'd0};
                    cword_next  = work_reg.cword;
                    wlo_next    = work_reg.wlo;
                    whi_next    = work_reg.whi;
                end
                else
                begin
                    status_next = ST_DENIED;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= '0;
            chan_out_reg  <= '0;
            block_reg     <= 1'b0;
            offset_reg    <= '0;
            cword_reg     <= '0;
            wlo_reg       <= '0;
            whi_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            chan_out_reg  <= chan_out_next;
            block_reg     <= block_next;
            offset_reg    <= offset_next;
            cword_reg     <= cword_next;
            wlo_reg       <= wlo_next;
            whi_reg       <= whi_next;
        end
    end

endmodule

@@ hdl/pmic_arbiter_channel_translator_top.sv @@
// A request's slot table read is registered at pop; the result is built in S_EVAL, or in S_PERM
// after a registered channel writer read for a write that passes the slot check. The back
// sequencer takes a new entry only from S_IDLE, so it is through with one before the next.
// Reset: rst_n clears control state, then a sweep over all PERIPH_IDS slot entries (4096 by default)
// clears the slot table while in_stall is held high; own_env resets to 0.
// Top level: config register, front end, work queue, back end. Uses pact_pkg.
module pmic_arbiter_channel_translator_top
    import pact_pkg::*;
#(
    parameter int PERIPH_IDS  = DEF_PERIPH_IDS,
    parameter int CHANNELS    = DEF_CHANNELS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [ENV_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [CMD_W-1:0]     cmd,
    input  logic [CHAN_W-1:0]    channel_index,
    input  logic [MAP_W-1:0]     map_word,
    input  logic [ENV_W-1:0]     owner_word,
    input  logic [SID_W-1:0]     slave_id,
    input  logic [ADDR_W-1:0]    reg_address,
    input  logic [LEN_W-1:0]     byte_count,
    input  logic [DATA_W-1:0]    write_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [STATUS_W-1:0]  status,
    output logic [CHAN_W-1:0]    channel_out,
    output logic                 reg_block,
    output logic [OFFSET_W-1:0]  reg_offset,
    output logic [CWORD_W-1:0]   command_word,
    output logic [WORD_W-1:0]    write_word_lo,
    output logic [WORD_W-1:0]    write_word_hi
);

    logic [ENV_W-1:0] own_env_reg;
    logic             busy;
    logic             push;
    logic             pop;
    entry_t           push_entry;
    entry_t           head;
    q_status_t        q_status;

    // Execution environment register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_env_reg <= '0;
        end
        else if (cfg_write)
        begin
            own_env_reg <= cfg_data;
        end
    end

    pact_front #(
        .PERIPH_IDS (PERIPH_IDS),
        .CHANNELS   (CHANNELS)
    ) u_front (
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .channel_index (channel_index),
        .map_word      (map_word),
        .owner_word    (owner_word),
        .slave_id      (slave_id),
        .reg_address   (reg_address),
        .byte_count    (byte_count),
        .write_data    (write_data),
        .busy          (busy),
        .q_status      (q_status),
        .push          (push),
        .push_entry    (push_entry)
    );

    pact_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_status   (q_status)
    );

    pact_back #(
        .PERIPH_IDS (PERIPH_IDS),
        .CHANNELS   (CHANNELS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .own_env       (own_env_reg),
        .head          (head),
        .q_status      (q_status),
        .pop           (pop),
        .busy          (busy),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .channel_out   (channel_out),
        .reg_block     (reg_block),
        .reg_offset    (reg_offset),
        .command_word  (command_word),
        .write_word_lo (write_word_lo),
        .write_word_hi (write_word_hi)
    );

endmodule
